// ===== src/ctt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the commit transaction tracker.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned SeqW  = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 32;

  localparam logic [TimeW-1:0] WindowReset = TimeW'(10000);

  typedef enum logic [2:0] {
    REQ_BEGIN   = 3'd0,
    REQ_CLAIM   = 3'd1,
    REQ_PREP    = 3'd2,
    REQ_POLL    = 3'd3,
    REQ_QUERY   = 3'd4,
    REQ_TAKE    = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    CODE_NONE    = 2'd0,
    CODE_OK      = 2'd1,
    CODE_BUSY    = 2'd2,
    CODE_CFG_ERR = 2'd3
  } code_e;

  typedef struct packed {
    req_type_e              req_type;
    logic [SeqW-1:0]        seq;
    logic                   prepare_ok;
    logic [CntW-1:0]        store_fail_count;
    logic                   store_committing;
    logic                   store_dirty;
    logic [TimeW-1:0]       now_ms;
  } req_t;

  typedef struct packed {
    code_e                  code;
    logic                   granted;
    logic [SeqW-1:0]        seq;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ctt_req_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_req_reg
// Input register stage: holds one request until the tracker consumes it.
// ----------------------------------------------------------------------------
module ctt_req_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ctt_pkg::req_t req_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output ctt_pkg::req_t      req_o
);
  import ctt_pkg::*;

  logic  valid_q;
  req_t  req_q;
  logic  accept;

  // a held request blocks the port only when it cannot move on this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule
`default_nettype wire

// ===== src/ctt_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_tracker
// Transaction state and the per-request decision logic.
// ----------------------------------------------------------------------------
module ctt_tracker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ctt_pkg::TimeW-1:0]  cfg_wdata_i,
  input  wire logic                       fire_i,
  input  wire ctt_pkg::req_t              req_i,
  output ctt_pkg::result_t                result_o
);
  import ctt_pkg::*;

  logic [TimeW-1:0] window_q;
  logic             txn_active_q,   txn_active_d;
  logic             prep_req_q,     prep_req_d;
  logic             prep_done_q,    prep_done_d;
  logic             prep_failed_q,  prep_failed_d;
  logic             term_pend_q,    term_pend_d;
  code_e            term_code_q,    term_code_d;
  logic [SeqW-1:0]  cur_seq_q,      cur_seq_d;
  logic [CntW-1:0]  fail_base_q,    fail_base_d;
  logic             done_valid_q,   done_valid_d;
  logic [SeqW-1:0]  done_seq_q,     done_seq_d;
  code_e            done_code_q,    done_code_d;
  logic [TimeW-1:0] done_time_q,    done_time_d;

  logic [TimeW-1:0] age;
  logic             recent;
  logic             finish;
  code_e            finish_code;

  // wrap-safe age of the last completion
  assign age    = req_i.now_ms - done_time_q;
  assign recent = done_valid_q && (done_seq_q == req_i.seq) && (age <= window_q);

  always_comb begin
    txn_active_d  = txn_active_q;
    prep_req_d    = prep_req_q;
    prep_done_d   = prep_done_q;
    prep_failed_d = prep_failed_q;
    term_pend_d   = term_pend_q;
    term_code_d   = term_code_q;
    cur_seq_d     = cur_seq_q;
    fail_base_d   = fail_base_q;
    done_valid_d  = done_valid_q;
    done_seq_d    = done_seq_q;
    done_code_d   = done_code_q;
    done_time_d   = done_time_q;
    finish        = 1'b0;
    finish_code   = CODE_NONE;
    result_o      = '{code: CODE_NONE, granted: 1'b0, seq: '0};

    unique case (req_i.req_type)
      REQ_BEGIN: begin
        if (txn_active_q) begin
          result_o.code = (cur_seq_q == req_i.seq) ? CODE_NONE : CODE_BUSY;
        end else if (term_pend_q && (cur_seq_q == req_i.seq)) begin
          result_o.code = CODE_NONE;
        end else if (recent) begin
          // replay the earlier completion
          cur_seq_d   = req_i.seq;
          term_code_d = done_code_q;
          term_pend_d = 1'b1;
        end else begin
          cur_seq_d     = req_i.seq;
          fail_base_d   = req_i.store_fail_count;
          prep_req_d    = 1'b0;
          prep_done_d   = 1'b0;
          prep_failed_d = 1'b0;
          term_pend_d   = 1'b0;
          term_code_d   = CODE_NONE;
          txn_active_d  = 1'b1;
        end
      end
      REQ_CLAIM: begin
        if (txn_active_q && !prep_req_q) begin
          prep_req_d       = 1'b1;
          result_o.granted = 1'b1;
        end
      end
      REQ_PREP: begin
        if (txn_active_q && prep_req_q) begin
          prep_done_d = 1'b1;
          if (!req_i.prepare_ok) begin
            prep_failed_d = 1'b1;
          end
        end
      end
      REQ_POLL: begin
        if (txn_active_q && prep_done_q) begin
          if (prep_failed_q || (req_i.store_fail_count != fail_base_q)) begin
            finish      = 1'b1;
            finish_code = CODE_CFG_ERR;
          end else if (!req_i.store_committing && !req_i.store_dirty) begin
            finish      = 1'b1;
            finish_code = CODE_OK;
          end
        end
      end
      REQ_QUERY: begin
        result_o.granted = recent;
      end
      REQ_TAKE: begin
        if (term_pend_q) begin
          result_o.granted = 1'b1;
          result_o.seq     = cur_seq_q;
          result_o.code    = term_code_q;
          term_pend_d      = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (finish) begin
      txn_active_d = 1'b0;
      term_code_d  = finish_code;
      done_seq_d   = cur_seq_q;
      done_code_d  = finish_code;
      done_valid_d = 1'b1;
      done_time_d  = req_i.now_ms;
      term_pend_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txn_active_q  <= 1'b0;
      prep_req_q    <= 1'b0;
      prep_done_q   <= 1'b0;
      prep_failed_q <= 1'b0;
      term_pend_q   <= 1'b0;
      term_code_q   <= CODE_NONE;
      cur_seq_q     <= '0;
      fail_base_q   <= '0;
      done_valid_q  <= 1'b0;
      done_seq_q    <= '0;
      done_code_q   <= CODE_NONE;
      done_time_q   <= '0;
    end else if (fire_i) begin
      txn_active_q  <= txn_active_d;
      prep_req_q    <= prep_req_d;
      prep_done_q   <= prep_done_d;
      prep_failed_q <= prep_failed_d;
      term_pend_q   <= term_pend_d;
      term_code_q   <= term_code_d;
      cur_seq_q     <= cur_seq_d;
      fail_base_q   <= fail_base_d;
      done_valid_q  <= done_valid_d;
      done_seq_q    <= done_seq_d;
      done_code_q   <= done_code_d;
      done_time_q   <= done_time_d;
    end
  end

`ifndef SYNTHESIS
  a_active_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txn_active_q |-> !term_pend_q)
    else $error("active transaction with a pending terminal result");

  a_done_needs_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_done_q |-> prep_req_q)
    else $error("prepare done without a claim");

  a_fail_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_failed_q |-> prep_done_q)
    else $error("prepare failure without prepare result");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (req_i.req_type == REQ_TAKE) && term_pend_q) |=> !term_pend_q)
    else $error("terminal result still pending after take");
`endif

endmodule
`default_nettype wire

// ===== src/commit_transaction_tracker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// commit_transaction_tracker_core
// Tracks one sequence-numbered save transaction against a flash store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o with the request fields alongside;
//   a request is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Every request yields exactly one result on out_valid_o/out_stall_i.
//   The request is held in an input register; the tracker state is updated
//   and the result register loaded once the result register is empty or
//   being drained. One request per cycle is sustained while the receiver
//   does not stall: the decision is a single pass of flag logic plus one
//   32-bit subtract and compare on the replay age. The user writes the
//   replay window through cfg_we_i/cfg_wdata_i only while idle; the block
//   does not enforce it. Reset clears the transaction state and sets the
//   window to 10000 ms. While the receiver stalls, the result holds; one more
//   request may wait in the input register, after which in_stall_o is raised.
// ----------------------------------------------------------------------------
module commit_transaction_tracker_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ctt_pkg::TimeW-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [2:0]                 req_type_i,
  input  wire logic [ctt_pkg::SeqW-1:0]   seq_i,
  input  wire logic                       prepare_ok_i,
  input  wire logic [ctt_pkg::CntW-1:0]   store_fail_count_i,
  input  wire logic                       store_committing_i,
  input  wire logic                       store_dirty_i,
  input  wire logic [ctt_pkg::TimeW-1:0]  now_ms_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      result_code_o,
  output logic                            granted_o,
  output logic [ctt_pkg::SeqW-1:0]        out_seq_o
);
  import ctt_pkg::*;

  req_t    req_in;
  req_t    req_q;
  logic    req_valid;
  logic    out_ready;
  logic    fire;
  result_t result;
  result_t result_q;
  logic    out_valid_q;

  assign req_in = '{
    req_type:         req_type_e'(req_type_i),
    seq:              seq_i,
    prepare_ok:       prepare_ok_i,
    store_fail_count: store_fail_count_i,
    store_committing: store_committing_i,
    store_dirty:      store_dirty_i,
    now_ms:           now_ms_i
  };

  // result register can take a new value when empty or being drained
  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = req_valid && out_ready;

  ctt_req_reg u_req_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .advance_i  (out_ready),
    .valid_o    (req_valid),
    .req_o      (req_q)
  );

  ctt_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .req_i       (req_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = result_q.code;
  assign granted_o     = result_q.granted;
  assign out_seq_o     = result_q.seq;

endmodule
`default_nettype wire

// ===== tb/commit_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// commit_tracker_checker
// Watches the request and result channels of the commit transaction tracker,
// keeps its own copy of the transaction state, predicts one result per
// accepted request and compares every accepted result against the oldest
// prediction. Hands the mismatch count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module commit_tracker_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ctt_pkg::TimeW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  logic [2:0]                req_type_i,
  input  logic [ctt_pkg::SeqW-1:0]  seq_i,
  input  logic                      prepare_ok_i,
  input  logic [ctt_pkg::CntW-1:0]  store_fail_count_i,
  input  logic                      store_committing_i,
  input  logic                      store_dirty_i,
  input  logic [ctt_pkg::TimeW-1:0] now_ms_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic [1:0]                result_code_o,
  input  logic                      granted_o,
  input  logic [ctt_pkg::SeqW-1:0]  out_seq_o,
  output int                        mismatch_cnt,
  output int                        pending_cnt
);
  import ctt_pkg::*;

  // tracker state as the checker sees it
  logic [TimeW-1:0] window_ms;
  logic             txn_open;
  logic             claim_taken;
  logic             prep_seen;
  logic             prep_bad;
  logic             term_waiting;
  code_e            term_code;
  logic [SeqW-1:0]  cur_seq;
  logic [CntW-1:0]  fail_base;
  logic             last_valid;
  logic [SeqW-1:0]  last_seq;
  code_e            last_code;
  logic [TimeW-1:0] last_time;

  result_t expected_results[$];
  req_t    seen_req;
  result_t predicted;
  result_t want;

  function automatic logic replayable(input logic [SeqW-1:0] s, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] age;
    age = now - last_time;
    return last_valid && (last_seq == s) && (age <= window_ms);
  endfunction

  task automatic close_txn(input code_e code, input logic [TimeW-1:0] now);
    txn_open     = 1'b0;
    term_code    = code;
    last_seq     = cur_seq;
    last_code    = code;
    last_valid   = 1'b1;
    last_time    = now;
    term_waiting = 1'b1;
  endtask

  task automatic track_request(input req_t r, output result_t res);
    res = '{code: CODE_NONE, granted: 1'b0, seq: '0};
    case (r.req_type)
      REQ_BEGIN: begin
        if (txn_open) begin
          if (cur_seq != r.seq) res.code = CODE_BUSY;
        end else if (term_waiting && cur_seq == r.seq) begin
          // same sequence still waiting to be taken: nothing to do
        end else if (replayable(r.seq, r.now_ms)) begin
          cur_seq      = r.seq;
          term_code    = last_code;
          term_waiting = 1'b1;
        end else begin
          cur_seq      = r.seq;
          fail_base    = r.store_fail_count;
          claim_taken  = 1'b0;
          prep_seen    = 1'b0;
          prep_bad     = 1'b0;
          term_waiting = 1'b0;
          term_code    = CODE_NONE;
          txn_open     = 1'b1;
        end
      end
      REQ_CLAIM: begin
        if (txn_open && !claim_taken) begin
          claim_taken = 1'b1;
          res.granted = 1'b1;
        end
      end
      REQ_PREP: begin
        if (txn_open && claim_taken) begin
          prep_seen = 1'b1;
          if (!r.prepare_ok) prep_bad = 1'b1;
        end
      end
      REQ_POLL: begin
        if (txn_open && prep_seen) begin
          if (prep_bad || r.store_fail_count != fail_base) close_txn(CODE_CFG_ERR, r.now_ms);
          else if (!r.store_committing && !r.store_dirty) close_txn(CODE_OK, r.now_ms);
        end
      end
      REQ_QUERY: res.granted = replayable(r.seq, r.now_ms);
      REQ_TAKE: begin
        if (term_waiting) begin
          res.granted  = 1'b1;
          res.seq      = cur_seq;
          res.code     = term_code;
          term_waiting = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms    = WindowReset;
      txn_open     = 1'b0;
      claim_taken  = 1'b0;
      prep_seen    = 1'b0;
      prep_bad     = 1'b0;
      term_waiting = 1'b0;
      term_code    = CODE_NONE;
      cur_seq      = '0;
      fail_base    = '0;
      last_valid   = 1'b0;
      last_seq     = '0;
      last_code    = CODE_NONE;
      last_time    = '0;
      expected_results.delete();
      mismatch_cnt = 0;
      pending_cnt  = 0;
    end else begin
      if (cfg_we_i) window_ms = cfg_wdata_i;

      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result code %0d granted %0b seq %0d", $time,
                   result_code_o, granted_o, out_seq_o);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (result_code_o != want.code) begin
            $display("%0t: result_code expected %0d actual %0d", $time, want.code,
                     result_code_o);
            mismatch_cnt++;
          end
          if (granted_o != want.granted) begin
            $display("%0t: granted expected %0b actual %0b", $time, want.granted, granted_o);
            mismatch_cnt++;
          end
          if (out_seq_o != want.seq) begin
            $display("%0t: out_seq expected %0d actual %0d", $time, want.seq, out_seq_o);
            mismatch_cnt++;
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        seen_req.req_type         = req_type_e'(req_type_i);
        seen_req.seq              = seq_i;
        seen_req.prepare_ok       = prepare_ok_i;
        seen_req.store_fail_count = store_fail_count_i;
        seen_req.store_committing = store_committing_i;
        seen_req.store_dirty      = store_dirty_i;
        seen_req.now_ms           = now_ms_i;
        track_request(seen_req, predicted);
        expected_results.push_back(predicted);
      end

      pending_cnt = expected_results.size();
    end
  end

endmodule

// ===== tb/tb_commit_transaction_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_commit_transaction_tracker_core
// Drives directed and random save-transaction request streams through the
// tracker under several replay windows, with random gaps on the request side
// and random stalls on the result side. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_commit_transaction_tracker_core;
  import ctt_pkg::*;

  localparam logic [2:0] REQ_BAD_A  = 3'd6;
  localparam logic [2:0] REQ_BAD_B  = 3'd7;
  localparam int         StuckLimit = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TimeW-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        req_type_i;
  logic [SeqW-1:0]   seq_i;
  logic              prepare_ok_i;
  logic [CntW-1:0]   store_fail_count_i;
  logic              store_committing_i;
  logic              store_dirty_i;
  logic [TimeW-1:0]  now_ms_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        result_code_o;
  logic              granted_o;
  logic [SeqW-1:0]   out_seq_o;

  int               mismatch_cnt;
  int               pending_cnt;
  int               stuck_cycles;
  int unsigned      n_sent;
  logic             calm;
  logic [TimeW-1:0] now_t;
  logic [TimeW-1:0] win_shadow;
  logic [CntW-1:0]  fail_ctr;

  commit_transaction_tracker_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .seq_i              (seq_i),
    .prepare_ok_i       (prepare_ok_i),
    .store_fail_count_i (store_fail_count_i),
    .store_committing_i (store_committing_i),
    .store_dirty_i      (store_dirty_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_code_o      (result_code_o),
    .granted_o          (granted_o),
    .out_seq_o          (out_seq_o)
  );

  commit_tracker_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .seq_i              (seq_i),
    .prepare_ok_i       (prepare_ok_i),
    .store_fail_count_i (store_fail_count_i),
    .store_committing_i (store_committing_i),
    .store_dirty_i      (store_dirty_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_code_o      (result_code_o),
    .granted_o          (granted_o),
    .out_seq_o          (out_seq_o),
    .mismatch_cnt       (mismatch_cnt),
    .pending_cnt        (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side stalls at random except during calm stretches
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = !calm && ($urandom_range(0, 99) < 29);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic step_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      now_t = now_t + $urandom_range(0, 3);
    end else if (pick < 90) begin
      // land right around the edge of the replay window
      now_t = now_t + win_shadow - 2 + $urandom_range(0, 4);
    end else begin
      now_t = $urandom();
    end
  endtask

  task automatic send_req(input req_type_e kind, input logic [SeqW-1:0] s, input logic ok,
                          input logic [CntW-1:0] fails, input logic comm, input logic dirty);
    while (!calm && $urandom_range(0, 99) < 29) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i         = 1'b1;
    req_type_i         = kind;
    seq_i              = s;
    prepare_ok_i       = ok;
    store_fail_count_i = fails;
    store_committing_i = comm;
    store_dirty_i      = dirty;
    now_ms_i           = now_t;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    step_time();
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [TimeW-1:0] value);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    win_shadow  = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic send_noise();
    send_req(req_type_e'(3'($urandom())), 8'($urandom()), 1'($urandom()),
             ($urandom_range(0, 1) != 0) ? fail_ctr : $urandom(),
             1'($urandom()), 1'($urandom()));
  endtask

  // one save transaction from begin to take, with occasional detours
  task automatic run_txn();
    logic [SeqW-1:0] s;
    logic            comm;
    logic            dirty;
    int              polls;
    s = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) fail_ctr = $urandom();
    send_req(REQ_BEGIN, s, 1'($urandom()), fail_ctr, 1'($urandom()), 1'($urandom()));
    if ($urandom_range(0, 4) == 0) send_req(REQ_BEGIN, s + 8'd1, 1'b0, fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 4) == 0) send_req(REQ_BEGIN, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 6) == 0) send_req(REQ_POLL, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    send_req(REQ_CLAIM, s, 1'($urandom()), fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 4) == 0) send_req(REQ_CLAIM, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    // broken sequence: walk away before the prepare result
    if ($urandom_range(0, 9) == 0) return;
    send_req(REQ_PREP, s, $urandom_range(0, 99) < 85, fail_ctr, 1'($urandom()),
             1'($urandom()));
    polls = $urandom_range(0, 3);
    repeat (polls) begin
      comm  = 1'($urandom());
      dirty = 1'($urandom());
      if (!comm && !dirty) comm = 1'b1;
      if ($urandom_range(0, 19) == 0) fail_ctr = fail_ctr + 1;
      send_req(REQ_POLL, s, 1'($urandom()), fail_ctr, comm, dirty);
    end
    send_req(REQ_POLL, s, 1'($urandom()), fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 9) < 8) send_req(REQ_TAKE, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 6) == 0) send_req(REQ_TAKE, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 9) < 4) send_req(REQ_QUERY, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      send_req(REQ_BEGIN, s, 1'b0, fail_ctr, 1'b0, 1'b0);
      send_req(REQ_TAKE, s, 1'b0, fail_ctr, 1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(input int unsigned upto);
    while (n_sent < upto) begin
      if ($urandom_range(0, 99) < 80) run_txn();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    req_type_i         = REQ_BEGIN;
    seq_i              = '0;
    prepare_ok_i       = 1'b0;
    store_fail_count_i = '0;
    store_committing_i = 1'b0;
    store_dirty_i      = 1'b0;
    now_ms_i           = '0;
    calm               = 1'b0;
    n_sent             = 0;
    win_shadow         = WindowReset;
    fail_ctr           = $urandom();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing in flight yet
    now_t = $urandom();
    send_req(REQ_TAKE, '0, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_CLAIM, '0, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_PREP, '0, 1'b1, '0, 1'b0, 1'b0);
    send_req(REQ_POLL, '0, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_QUERY, '0, 1'b0, '0, 1'b0, 1'b0);
    send_req(req_type_e'(REQ_BAD_A), '1, 1'b1, '1, 1'b1, 1'b1);
    send_req(req_type_e'(REQ_BAD_B), '1, 1'b1, '1, 1'b1, 1'b1);

    // begin, dedup and busy, then a fail count change ends it with an error
    now_t = 32'hFFFF_FFF0;
    send_req(REQ_BEGIN, 8'hFF, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_BEGIN, 8'h00, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_BEGIN, 8'hFF, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_POLL, 8'hFF, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_CLAIM, 8'hFF, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_CLAIM, 8'hFF, 1'b0, '1, 1'b0, 1'b0);
    send_req(REQ_PREP, 8'hFF, 1'b1, '1, 1'b0, 1'b0);
    send_req(REQ_POLL, 8'hFF, 1'b0, '1, 1'b1, 1'b1);
    now_t = 32'hFFFF_FFF8;
    send_req(REQ_POLL, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_BEGIN, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_TAKE, 8'hFF, 1'b0, '0, 1'b0, 1'b0);

    // replay window edges across the time wrap
    now_t = 32'hFFFF_FFF8 + WindowReset;
    send_req(REQ_QUERY, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    now_t = 32'hFFFF_FFF8 + WindowReset + 1;
    send_req(REQ_QUERY, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    now_t = 32'hFFFF_FFF8 + WindowReset;
    send_req(REQ_BEGIN, 8'hFF, 1'b0, '0, 1'b0, 1'b0);
    send_req(REQ_TAKE, 8'hFF, 1'b0, '0, 1'b0, 1'b0);

    run_phase(n_sent + 90);
    write_window('0);
    run_phase(n_sent + 90);
    write_window('1);
    run_phase(n_sent + 90);
    write_window(32'($urandom_range(1, 20)));
    calm = 1'b1;
    run_phase(n_sent + 90);
    calm = 1'b0;
    write_window($urandom());
    run_phase(n_sent + 90);

    wait_idle();
    repeat (6) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
